### rtl/rks_pkg.sv
package rks_pkg;

   localparam int MAX_LEN    = 64;
   localparam int VALUE_BITS = 8;

   // field widths of the channels
   localparam int POS_W = 7;
   localparam int VAL_W = 8;
   localparam int LEN_W = 7;

   // count store: one row of trie nodes for each Fenwick node
   localparam int CNT_W  = 7;
   localparam int ACC_W  = 8;
   localparam int J_W    = POS_W + 1;
   localparam int ROW_W  = $clog2(MAX_LEN);
   localparam int NODE_W = VALUE_BITS + 1;
   localparam int ADDR_W = ROW_W + NODE_W;
   localparam int NODES  = 1 << ADDR_W;
   localparam int LVL_W  = $clog2(VALUE_BITS + 1);

   localparam logic FUNC_SET   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

endpackage

### rtl/rks_req_if.sv
interface rks_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [rks_pkg::POS_W-1:0]  position;
   logic [rks_pkg::POS_W-1:0]  right_end;
   logic [rks_pkg::VAL_W-1:0]  new_value;
   logic [rks_pkg::POS_W-1:0]  rank_k;

   modport source (output valid, func, position, right_end, new_value, rank_k, input ready);
   modport sink   (input valid, func, position, right_end, new_value, rank_k, output ready);
endinterface

### rtl/rks_rsp_if.sv
interface rks_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rks_pkg::VAL_W-1:0]  answer_value;
   logic                       error;

   modport source (output valid, answer_value, error, input ready);
   modport sink   (input valid, answer_value, error, output ready);
endinterface

### rtl/range_kth_smallest_with_updates_top.sv
// Range k-th smallest with point updates.
// req_ch (valid/ready) carries set items (func 0) and query items (func 1).
// rsp_ch (valid/ready) returns one item for each query and none for a set.
// csr_we/csr_wdata write active_length; the user must do so only while the
// block is idle, which the block itself does not enforce. One item is worked
// on at a time; req_ch.ready is high only when idle. A set walks the nine trie
// levels of each Fenwick node from the position up to 64, with a gap after each
// walk; overwriting a filled position walks twice (remove old value, add
// new one). A query runs 9 rounds over the count memory, each reading the
// Fenwick nodes of right_end and of position-1; a rank outside the range
// count ends after the first round. The count memory has a single read port,
// one Fenwick node per cycle. After reset the count memory is zeroed, one
// entry a cycle, all 32768 entries, before req_ch.ready rises; configuration
// writes are taken meanwhile. The result sits in an output register; a
// stalled receiver holds it, and the block goes on with the next item until
// it has a new result to load.
module range_kth_smallest_with_updates_top (
   input  logic                       clock,
   input  logic                       reset,
   rks_req_if.sink                    req_ch,
   rks_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [rks_pkg::LEN_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SET_RD, S_WALK, S_GAP, S_Q_WALK, S_Q_DECIDE, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [rks_pkg::LEN_W-1:0]      alen_ff;
   logic [rks_pkg::ADDR_W-1:0]     clr_ff, clr_in;
   logic [rks_pkg::POS_W-1:0]      pos_ff, pos_in, right_ff, right_in, k_ff, k_in;
   logic [rks_pkg::VALUE_BITS-1:0] upd_val_ff, upd_val_in, walk_val_ff, walk_val_in;
   logic                           dec_ff, dec_in;
   logic [rks_pkg::J_W-1:0]        j_ff, j_in;
   logic [rks_pkg::LVL_W-1:0]      lvl_ff, lvl_in;
   logic [rks_pkg::NODE_W-1:0]     node_ff, node_in, cur_node_ff, cur_node_in;
   logic                           wr_valid_ff, wr_valid_in;
   logic [rks_pkg::ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                           phase_ff, phase_in, rd_pend_ff, rd_pend_in;
   logic                           rd_sub_ff, rd_sub_in;
   logic [rks_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic [rks_pkg::MAX_LEN-1:0]    present_ff, present_in;
   logic                           res_err_ff, res_err_in;
   logic [rks_pkg::VAL_W-1:0]      res_val_ff, res_val_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_err_ff, rsp_err_in;
   logic [rks_pkg::VAL_W-1:0]      rsp_val_ff, rsp_val_in;

   logic [rks_pkg::ADDR_W-1:0]     ram_raddr, ram_waddr;
   logic [rks_pkg::CNT_W-1:0]      ram_rdata, ram_wdata;
   logic                           ram_we, elem_we;
   logic [rks_pkg::VALUE_BITS-1:0] elem_rdata;
   logic [rks_pkg::POS_W-1:0]      req_pos_m1, pos_m1;
   logic [rks_pkg::ROW_W-1:0]      pos_idx;
   logic [rks_pkg::J_W-1:0]        j_low, j_m1;
   logic [rks_pkg::VALUE_BITS-1:0] val_shift;
   logic [rks_pkg::NODE_W-1:0]     child;

   assign req_pos_m1 = req_ch.position - rks_pkg::POS_W'(1);
   assign pos_m1     = pos_ff - rks_pkg::POS_W'(1);
   assign pos_idx    = pos_m1[rks_pkg::ROW_W-1:0];
   assign j_low      = j_ff & (~j_ff + rks_pkg::J_W'(1));
   assign j_m1       = j_ff - rks_pkg::J_W'(1);
   assign val_shift  = walk_val_ff >> (rks_pkg::LVL_W'(rks_pkg::VALUE_BITS - 1) - lvl_ff);
   assign child      = {node_ff[rks_pkg::NODE_W-2:0], val_shift[0]};

   assign ram_raddr = (state_ff == S_Q_WALK) ? {j_m1[rks_pkg::ROW_W-1:0], cur_node_ff}
                                             : {j_m1[rks_pkg::ROW_W-1:0], node_ff};
   assign ram_we    = (state_ff == S_CLEAR) || wr_valid_ff;
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : wr_addr_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? '0
                    : (dec_ff ? ram_rdata - rks_pkg::CNT_W'(1)
                              : ram_rdata + rks_pkg::CNT_W'(1));
   assign elem_we   = (state_ff == S_SET_RD);

   rks_ram #(.WIDTH(rks_pkg::CNT_W), .DEPTH(rks_pkg::NODES)) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rks_ram #(.WIDTH(rks_pkg::VALUE_BITS), .DEPTH(rks_pkg::MAX_LEN)) u_value_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (pos_idx),
      .wdata (upd_val_ff),
      .raddr (req_pos_m1[rks_pkg::ROW_W-1:0]),
      .rdata (elem_rdata)
   );

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.answer_value = rsp_val_ff;
   assign rsp_ch.error        = rsp_err_ff;

   always_comb begin
      logic [rks_pkg::NODE_W-1:0] q_node;
      logic [rks_pkg::J_W-1:0]    j_next;
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      right_in     = right_ff;
      k_in         = k_ff;
      upd_val_in   = upd_val_ff;
      walk_val_in  = walk_val_ff;
      dec_in       = dec_ff;
      j_in         = j_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      cur_node_in  = cur_node_ff;
      wr_valid_in  = 1'b0;
      wr_addr_in   = wr_addr_ff;
      phase_in     = phase_ff;
      rd_pend_in   = 1'b0;
      rd_sub_in    = rd_sub_ff;
      acc_in       = acc_ff;
      present_in   = present_ff;
      res_err_in   = res_err_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_err_in   = rsp_err_ff;
      rsp_val_in   = rsp_val_ff;
      q_node       = '0;
      j_next       = j_ff + j_low;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + rks_pkg::ADDR_W'(1);
            if (clr_ff == rks_pkg::ADDR_W'(rks_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               pos_in     = req_ch.position;
               right_in   = req_ch.right_end;
               k_in       = req_ch.rank_k;
               upd_val_in = req_ch.new_value[rks_pkg::VALUE_BITS-1:0];
               if (req_ch.func == rks_pkg::FUNC_SET) begin
                  // drop a set outside the active positions
                  if (req_ch.position != '0 && req_ch.position <= alen_ff) begin
                     state_in = S_SET_RD;
                  end
               end else if (req_ch.position == '0 || req_ch.position > req_ch.right_end
                            || req_ch.right_end > alen_ff) begin
                  res_err_in = 1'b1;
                  res_val_in = '0;
                  state_in   = S_EMIT;
               end else begin
                  j_in        = {1'b0, req_ch.right_end};
                  cur_node_in = rks_pkg::NODE_W'(1);
                  lvl_in      = '0;
                  phase_in    = 1'b0;
                  acc_in      = '0;
                  state_in    = S_Q_WALK;
               end
            end
         end
         S_SET_RD: begin
            present_in[pos_idx] = 1'b1;
            dec_in      = present_ff[pos_idx];
            walk_val_in = present_ff[pos_idx] ? elem_rdata : upd_val_ff;
            j_in        = {1'b0, pos_ff};
            lvl_in      = '0;
            node_in     = rks_pkg::NODE_W'(1);
            state_in    = S_WALK;
         end
         S_WALK: begin
            // read this node now, write it back next cycle
            wr_valid_in = 1'b1;
            wr_addr_in  = ram_raddr;
            if (lvl_ff == rks_pkg::LVL_W'(rks_pkg::VALUE_BITS)) begin
               lvl_in  = '0;
               node_in = rks_pkg::NODE_W'(1);
               j_in    = j_next;
               if (j_next > rks_pkg::J_W'(rks_pkg::MAX_LEN)) begin
                  state_in = S_GAP;
               end
            end else begin
               lvl_in  = lvl_ff + rks_pkg::LVL_W'(1);
               node_in = child;
            end
         end
         S_GAP: begin
            if (dec_ff) begin
               dec_in      = 1'b0;
               walk_val_in = upd_val_ff;
               j_in        = {1'b0, pos_ff};
               lvl_in      = '0;
               node_in     = rks_pkg::NODE_W'(1);
               state_in    = S_WALK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_Q_WALK: begin
            if (rd_pend_ff) begin
               acc_in = rd_sub_ff ? acc_ff - rks_pkg::ACC_W'(ram_rdata)
                                  : acc_ff + rks_pkg::ACC_W'(ram_rdata);
            end
            if (j_ff != '0) begin
               rd_pend_in = 1'b1;
               rd_sub_in  = phase_ff;
               j_in       = j_ff - j_low;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               j_in     = {1'b0, pos_m1};
            end else begin
               state_in = S_Q_DECIDE;
            end
         end
         S_Q_DECIDE: begin
            j_in     = {1'b0, right_ff};
            phase_in = 1'b0;
            acc_in   = '0;
            state_in = S_Q_WALK;
            if (lvl_ff == '0) begin
               if (k_ff == '0 || {1'b0, k_ff} > acc_ff) begin
                  res_err_in = 1'b1;
                  res_val_in = '0;
                  state_in   = S_EMIT;
               end else begin
                  cur_node_in = rks_pkg::NODE_W'(2);
                  lvl_in      = rks_pkg::LVL_W'(1);
               end
            end else begin
               if ({1'b0, k_ff} <= acc_ff) begin
                  q_node = cur_node_ff;
               end else begin
                  k_in   = k_ff - acc_ff[rks_pkg::POS_W-1:0];
                  q_node = cur_node_ff | rks_pkg::NODE_W'(1);
               end
               if (lvl_ff == rks_pkg::LVL_W'(rks_pkg::VALUE_BITS)) begin
                  res_err_in = 1'b0;
                  res_val_in = rks_pkg::VAL_W'(q_node[rks_pkg::VALUE_BITS-1:0]);
                  state_in   = S_EMIT;
               end else begin
                  cur_node_in = {q_node[rks_pkg::NODE_W-2:0], 1'b0};
                  lvl_in      = lvl_ff + rks_pkg::LVL_W'(1);
               end
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = res_err_ff;
               rsp_val_in   = res_val_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         alen_ff      <= rks_pkg::LEN_W'(rks_pkg::MAX_LEN);
         present_ff   <= '0;
         wr_valid_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dec_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         present_ff   <= present_in;
         wr_valid_ff  <= wr_valid_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         dec_ff       <= dec_in;
         if (csr_we) begin
            if (csr_wdata == '0) begin
               alen_ff <= rks_pkg::LEN_W'(1);
            end else if (csr_wdata > rks_pkg::LEN_W'(rks_pkg::MAX_LEN)) begin
               alen_ff <= rks_pkg::LEN_W'(rks_pkg::MAX_LEN);
            end else begin
               alen_ff <= csr_wdata;
            end
         end
      end
      pos_ff      <= pos_in;
      right_ff    <= right_in;
      k_ff        <= k_in;
      upd_val_ff  <= upd_val_in;
      walk_val_ff <= walk_val_in;
      j_ff        <= j_in;
      lvl_ff      <= lvl_in;
      node_ff     <= node_in;
      cur_node_ff <= cur_node_in;
      wr_addr_ff  <= wr_addr_in;
      phase_ff    <= phase_in;
      rd_sub_ff   <= rd_sub_in;
      acc_ff      <= acc_in;
      res_err_ff  <= res_err_in;
      res_val_ff  <= res_val_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_val_ff  <= rsp_val_in;
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_we)
      else $error("count memory written while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_Q_DECIDE |-> acc_ff <= rks_pkg::ACC_W'(rks_pkg::MAX_LEN))
      else $error("range count above the number of positions");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_val_ff == '0)
      else $error("error result with nonzero value");

   a_present_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SET_RD |=> present_ff[$past(pos_idx)])
      else $error("position not marked filled after a set");

endmodule

### rtl/rks_ram.sv
module rks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### bench/rks_checker.sv
module rks_checker (
   input  logic                       clock,
   input  logic                       reset,
   rks_req_if                         req_mon,
   rks_rsp_if                         rsp_mon,
   input  logic                       csr_we,
   input  logic [rks_pkg::LEN_W-1:0]  csr_wdata,
   output int                         fail_count,
   output int                         pending_count,
   output int                         query_count,
   output int                         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rks_pkg::VAL_W-1:0] answer_value;
      logic                      error;
   } answer_type;

   answer_type                answers_due[$];
   logic [rks_pkg::VAL_W-1:0] cell_value [1:rks_pkg::MAX_LEN];
   logic                      cell_filled[1:rks_pkg::MAX_LEN];
   int                        span_len;

   assign pending_count = answers_due.size();

   // k-th smallest by sorting the filled values of the range
   function automatic answer_type rank_answer(int lo, int hi, int k);
      answer_type                res;
      logic [rks_pkg::VAL_W-1:0] pool[$];
      res = '{answer_value: '0, error: 1'b1};
      if (lo < 1 || lo > hi || hi > span_len) return res;
      for (int p = lo; p <= hi; p++)
         if (cell_filled[p]) pool.push_back(cell_value[p]);
      if (k < 1 || k > pool.size()) return res;
      pool.sort();
      res.answer_value = pool[k-1];
      res.error        = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         span_len = rks_pkg::MAX_LEN;
         for (int p = 1; p <= rks_pkg::MAX_LEN; p++) begin
            cell_value[p]  = '0;
            cell_filled[p] = 1'b0;
         end
         answers_due.delete();
         fail_count  = 0;
         query_count = 0;
         error_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == rks_pkg::FUNC_SET) begin
               if (req_mon.position >= 1 && int'(req_mon.position) <= span_len) begin
                  cell_value[req_mon.position]  = req_mon.new_value;
                  cell_filled[req_mon.position] = 1'b1;
               end
            end else begin
               want = rank_answer(int'(req_mon.position), int'(req_mon.right_end),
                                  int'(req_mon.rank_k));
               answers_due.push_back(want);
               query_count++;
               if (want.error) error_count++;
            end
         end
         // the new length applies from the next item on
         if (csr_we)
            span_len = (csr_wdata < 1) ? 1
                     : (int'(csr_wdata) > rks_pkg::MAX_LEN) ? rks_pkg::MAX_LEN
                     : int'(csr_wdata);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{answer_value: rsp_mon.answer_value, error: rsp_mon.error};
            if (answers_due.size() == 0) begin
               $error("answer item with none expected");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.answer_value !== want.answer_value) begin
                  $error("answer_value: expected %0d, actual %0d",
                         want.answer_value, got.answer_value);
                  fail_count++;
               end
               if (got.error !== want.error) begin
                  $error("error: expected %0d, actual %0d", want.error, got.error);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

### bench/range_kth_smallest_with_updates_top_tb.sv
module range_kth_smallest_with_updates_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 2_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [rks_pkg::LEN_W-1:0]  csr_wdata = '0;
   int                         fail_count, pending_count, query_count, error_count;
   longint                     cycles = 0;
   bit                         calm = 1'b0;
   bit                         hold_off = 1'b0;
   int                         sent = 0;

   rks_req_if req_ch();
   rks_rsp_if rsp_ch();

   range_kth_smallest_with_updates_top uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   rks_checker chk (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending_count(pending_count), .query_count(query_count),
      .error_count(error_count)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = rks_pkg::FUNC_SET;
      req_ch.position = '0;
      req_ch.right_end = '0;
      req_ch.new_value = '0;
      req_ch.rank_k = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("range_kth_smallest_with_updates_top regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, none while calm, nothing during the hold-off
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 26);
   end

   // valid stays high after an accept; the next item or an idle drops it
   task automatic send_item(logic f, int pos, int rgt, int val, int k);
      if (!calm && $urandom_range(99) < 26) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 26) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.position  <= rks_pkg::POS_W'(pos);
      req_ch.right_end <= rks_pkg::POS_W'(rgt);
      req_ch.new_value <= rks_pkg::VAL_W'(val);
      req_ch.rank_k    <= rks_pkg::POS_W'(k);
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic drain;
      int guard;
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      // a set still walking gives no result; let it finish
      for (guard = 0; guard < 3000; guard++) @(posedge clock);
   endtask

   task automatic write_length(int len);
      csr_we    <= 1'b1;
      csr_wdata <= rks_pkg::LEN_W'(len);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int count, int len);
      int lo, hi;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 45) begin
            // mostly in range, now and then off the end
            lo = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(len, 1);
            send_item(rks_pkg::FUNC_SET, lo, $urandom_range(127), $urandom_range(255),
                      $urandom_range(127));
         end else if ($urandom_range(9) == 0) begin
            send_item(rks_pkg::FUNC_QUERY, $urandom_range(127), $urandom_range(127),
                      $urandom_range(255), $urandom_range(127));
         end else begin
            lo = $urandom_range(len, 1);
            hi = $urandom_range(len, lo);
            send_item(rks_pkg::FUNC_QUERY, lo, hi, $urandom_range(255),
                      $urandom_range(hi - lo + 2, ($urandom_range(19) == 0) ? 0 : 1));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_length(rks_pkg::MAX_LEN);
      // directed: empty store, extremes, bad range and bad rank
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 1);
      send_item(rks_pkg::FUNC_SET, 1, 0, 8'hff, 0);
      send_item(rks_pkg::FUNC_SET, rks_pkg::MAX_LEN, 127, 8'h00, 127);
      send_item(rks_pkg::FUNC_SET, 0, 0, 8'h55, 0);
      send_item(rks_pkg::FUNC_SET, 65, 0, 8'haa, 0);
      send_item(rks_pkg::FUNC_SET, 127, 0, 8'h7f, 0);
      send_item(rks_pkg::FUNC_SET, 32, 0, 8'h80, 0);
      send_item(rks_pkg::FUNC_SET, 32, 0, 8'h01, 0);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 3);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 4);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 0);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 127);
      send_item(rks_pkg::FUNC_QUERY, 0, 5, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, 10, 9, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, 1, 65, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, 127, 127, 8'hff, 1);
      send_item(rks_pkg::FUNC_QUERY, 2, 31, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, rks_pkg::MAX_LEN, rks_pkg::MAX_LEN, 0, 1);
      drain();
      // length extremes, including the clamped writes
      write_length(0);
      send_item(rks_pkg::FUNC_SET, 2, 0, 9, 0);
      send_item(rks_pkg::FUNC_QUERY, 1, 1, 0, 1);
      send_item(rks_pkg::FUNC_QUERY, 1, 2, 0, 1);
      drain();
      write_length(127);
      send_item(rks_pkg::FUNC_QUERY, 1, rks_pkg::MAX_LEN, 0, 3);
      // receiver holds off while items keep coming
      hold_off = 1'b1;
      fork
         begin
            for (int h = 0; h < 4000; h++) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(40, rks_pkg::MAX_LEN);
      join
      drain();
      calm = 1'b1;
      random_phase(300, rks_pkg::MAX_LEN);
      calm = 1'b0;
      drain();
      write_length(8);
      random_phase(500, 8);
      drain();
      write_length(1);
      random_phase(60, 1);
      drain();
      write_length(40);
      random_phase(400, 40);
      drain();
      write_length(rks_pkg::MAX_LEN);
      random_phase(500, rks_pkg::MAX_LEN);
      drain();
      $display("sent %0d items: %0d queries, %0d of them flagged as errors",
               sent, query_count, error_count);
      $display("lengths covered: 1, 8, 40, %0d, plus clamped writes of 0 and 127",
               rks_pkg::MAX_LEN);
      if (fail_count == 0)
         $display("range_kth_smallest_with_updates_top regression: pass");
      else
         $display("range_kth_smallest_with_updates_top regression: fail");
      $finish;
   end
endmodule
